### src/hla_pkg.sv
// ----------------------------------------------------------------------------
// hla_pkg
// Shared constants, operation codes and the Q2.14 sine table for the Hough
// line accumulator.
// ----------------------------------------------------------------------------
package hla_pkg;

   localparam int ANGLE_STEPS_DEF = 360;
   localparam int RHO_ROWS_DEF    = 1024;
   localparam int COORD_BITS_DEF  = 8;

   localparam int OP_BITS     = 2;
   localparam int ROW_IN_BITS = 10;
   localparam int ANGLE_BITS  = 9;
   localparam int OFFSET_BITS = 9;
   localparam int COUNT_BITS  = 17;
   localparam int DROP_BITS   = 9;
   localparam int TRIG_BITS   = 16;
   localparam int Q_SHIFT     = 14;

   localparam logic [OP_BITS-1:0] OP_VOTE       = 2'd0;
   localparam logic [OP_BITS-1:0] OP_READ       = 2'd1;
   localparam logic [OP_BITS-1:0] OP_READ_CLEAR = 2'd2;

   localparam logic [OFFSET_BITS-1:0] OFFSET_RESET = 9'd362;
   localparam logic [COUNT_BITS-1:0]  COUNT_MAX    = 17'd131071;

   localparam logic [9:0] QUARTER_TURN = 10'd90;
   localparam logic [9:0] HALF_TURN    = 10'd180;
   localparam logic [9:0] THREE_QUARTER_TURN = 10'd270;
   localparam logic [9:0] FULL_TURN    = 10'd360;

   localparam logic [14:0] QUARTER_SINE [0:90] = '{
      15'd0,     15'd286,   15'd572,   15'd857,   15'd1143,  15'd1428,  15'd1713,
      15'd1997,  15'd2280,  15'd2563,  15'd2845,  15'd3126,  15'd3406,  15'd3686,
      15'd3964,  15'd4240,  15'd4516,  15'd4790,  15'd5063,  15'd5334,  15'd5604,
      15'd5872,  15'd6138,  15'd6402,  15'd6664,  15'd6924,  15'd7182,  15'd7438,
      15'd7692,  15'd7943,  15'd8192,  15'd8438,  15'd8682,  15'd8923,  15'd9162,
      15'd9397,  15'd9630,  15'd9860,  15'd10087, 15'd10311, 15'd10531, 15'd10749,
      15'd10963, 15'd11174, 15'd11381, 15'd11585, 15'd11786, 15'd11982, 15'd12176,
      15'd12365, 15'd12551, 15'd12733, 15'd12911, 15'd13085, 15'd13255, 15'd13421,
      15'd13583, 15'd13741, 15'd13894, 15'd14044, 15'd14189, 15'd14330, 15'd14466,
      15'd14598, 15'd14726, 15'd14849, 15'd14968, 15'd15082, 15'd15191, 15'd15296,
      15'd15396, 15'd15491, 15'd15582, 15'd15668, 15'd15749, 15'd15826, 15'd15897,
      15'd15964, 15'd16026, 15'd16083, 15'd16135, 15'd16182, 15'd16225, 15'd16262,
      15'd16294, 15'd16322, 15'd16344, 15'd16362, 15'd16374, 15'd16382, 15'd16384
   };

   // sine in Q2.14 for 0 .. 2*360-1 degrees, unfolded from the quarter wave
   function automatic logic signed [TRIG_BITS-1:0] sine_q14(input logic [9:0] deg);
      logic [9:0]  d;
      logic [14:0] mag;
      logic        neg;
      d = (deg >= FULL_TURN) ? deg - FULL_TURN : deg;
      if (d <= QUARTER_TURN) begin
         mag = QUARTER_SINE[7'(d)];
         neg = 1'b0;
      end else if (d <= HALF_TURN) begin
         mag = QUARTER_SINE[7'(HALF_TURN - d)];
         neg = 1'b0;
      end else if (d <= THREE_QUARTER_TURN) begin
         mag = QUARTER_SINE[7'(d - HALF_TURN)];
         neg = 1'b1;
      end else begin
         mag = QUARTER_SINE[7'(FULL_TURN - d)];
         neg = 1'b1;
      end
      return neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
   endfunction

endpackage

### src/hough_line_accumulator_core.sv
// ----------------------------------------------------------------------------
// hough_line_accumulator_core
// Flow: an edge vote sweeps all angles through the pipeline and then drains;
//   reads and read-clears enter at the range check; other items go straight to
//   the response; every response waits out rsp stalls. One item at a time; an
//   edge vote does one read-modify-write per angle.
// Reset: a clearing pass writes zero to all RHO_ROWS*ANGLE_STEPS cells, one a
//   cycle; req_ready stays low, csr writes are taken.
// ----------------------------------------------------------------------------
module hough_line_accumulator_core
   import hla_pkg::*;
#(
   parameter int ANGLE_STEPS = ANGLE_STEPS_DEF,
   parameter int RHO_ROWS    = RHO_ROWS_DEF,
   parameter int COORD_BITS  = COORD_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,

   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [OP_BITS-1:0]     req_operation,
   input  logic [COORD_BITS-1:0]  req_pixel_x,
   input  logic [COORD_BITS-1:0]  req_pixel_y,
   input  logic                   req_pixel_is_edge,
   input  logic [ROW_IN_BITS-1:0] req_rho_row,
   input  logic [ANGLE_BITS-1:0]  req_angle_deg,

   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [COUNT_BITS-1:0]  rsp_cell_count,
   output logic [DROP_BITS-1:0]   rsp_dropped_votes,

   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [OFFSET_BITS-1:0] csr_rho_offset
);

   localparam int DEPTH     = RHO_ROWS * ANGLE_STEPS;
   localparam int ADDR_BITS = $clog2(DEPTH);
   localparam int ROW_BITS  = $clog2(RHO_ROWS);
   localparam int PROD_BITS = COORD_BITS + TRIG_BITS + 1;
   localparam int SUM_BITS  = PROD_BITS + 1;
   localparam int R_BITS    = COORD_BITS + 10;

   localparam logic [1:0] ST_CLEAR = 2'd0;
   localparam logic [1:0] ST_IDLE  = 2'd1;
   localparam logic [1:0] ST_SWEEP = 2'd2;
   localparam logic [1:0] ST_DRAIN = 2'd3;

   logic [1:0]             state_ff, state_in;
   logic [ADDR_BITS-1:0]   clr_addr_ff, clr_addr_in;
   logic [OFFSET_BITS-1:0] offset_ff, offset_in;
   logic [ANGLE_BITS-1:0]  angle_ff, angle_in;
   logic [COORD_BITS-1:0]  x_ff, y_ff;

   logic                          s1_valid_ff, s1_valid_in;
   logic [ANGLE_BITS-1:0]         s1_angle_ff;
   logic signed [TRIG_BITS-1:0]   s1_cos_ff, s1_sin_ff;
   logic                          s2_valid_ff;
   logic [ANGLE_BITS-1:0]         s2_angle_ff;
   logic signed [PROD_BITS-1:0]   s2_px_ff, s2_py_ff;
   logic                          s3_valid_ff, s3_valid_in;
   logic [OP_BITS-1:0]            s3_kind_ff, s3_kind_in;
   logic signed [R_BITS-1:0]      s3_row_ff, s3_row_in;
   logic [ANGLE_BITS-1:0]         s3_col_ff, s3_col_in;
   logic                          s4_valid_ff;
   logic [OP_BITS-1:0]            s4_kind_ff;
   logic                          s4_hit_ff, s4_hit_in;
   logic [ADDR_BITS-1:0]          s4_addr_ff;
   logic                          s5_valid_ff;
   logic [OP_BITS-1:0]            s5_kind_ff;
   logic                          s5_hit_ff;
   logic [ADDR_BITS-1:0]          s5_addr_ff;

   logic [COUNT_BITS-1:0] vote_mem [DEPTH];
   logic [COUNT_BITS-1:0] mem_rdata_ff;
   logic                  mem_we;
   logic [ADDR_BITS-1:0]  mem_waddr;
   logic [COUNT_BITS-1:0] mem_wdata;

   logic [DROP_BITS-1:0]  dropped_ff, dropped_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [COUNT_BITS-1:0] rsp_count_ff;
   logic [DROP_BITS-1:0]  rsp_dropped_ff;

   logic accept, is_read_op, pipe_empty, rsp_load;
   logic signed [TRIG_BITS-1:0] cos_val, sin_val;
   logic signed [SUM_BITS-1:0]  sum, sum_adj, rho_q;

   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;
   assign accept    = req_valid && req_ready;
   assign is_read_op = (req_operation == OP_READ) || (req_operation == OP_READ_CLEAR);
   assign pipe_empty = !(s1_valid_ff || s2_valid_ff || s3_valid_ff || s4_valid_ff
                         || s5_valid_ff);
   assign rsp_load  = (state_ff == ST_DRAIN) && pipe_empty && (!rsp_valid_ff || rsp_ready);

   // sequencer
   always_comb begin
      state_in    = state_ff;
      clr_addr_in = clr_addr_ff;
      angle_in    = angle_ff;
      s1_valid_in = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            clr_addr_in = clr_addr_ff + 1'b1;
            if (clr_addr_ff == ADDR_BITS'(DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               angle_in = '0;
               if (req_operation == OP_VOTE && req_pixel_is_edge) begin
                  state_in = ST_SWEEP;
               end else begin
                  state_in = ST_DRAIN;
               end
            end
         end
         ST_SWEEP: begin
            s1_valid_in = 1'b1;
            angle_in    = angle_ff + 1'b1;
            if (angle_ff == ANGLE_BITS'(ANGLE_STEPS - 1)) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign offset_in = (csr_valid && csr_ready) ? csr_rho_offset : offset_ff;

   // stage 0: trig lookup; cos(t) = sin(t + 90)
   assign sin_val = sine_q14(10'(angle_ff));
   assign cos_val = sine_q14(10'(angle_ff) + QUARTER_TURN);

   // stage 2 -> 3: rho truncated toward zero, plus offset
   assign sum     = SUM_BITS'(s2_px_ff) + SUM_BITS'(s2_py_ff);
   assign sum_adj = sum + (sum[SUM_BITS-1] ? SUM_BITS'((1 << Q_SHIFT) - 1) : SUM_BITS'(0));
   assign rho_q   = sum_adj >>> Q_SHIFT;

   always_comb begin
      if (accept && is_read_op) begin
         s3_valid_in = 1'b1;
         s3_kind_in  = req_operation;
         s3_row_in   = $signed(R_BITS'(req_rho_row));
         s3_col_in   = req_angle_deg;
      end else begin
         s3_valid_in = s2_valid_ff;
         s3_kind_in  = OP_VOTE;
         s3_row_in   = R_BITS'(rho_q) + $signed(R_BITS'(offset_ff));
         s3_col_in   = s2_angle_ff;
      end
   end

   // stage 3 -> 4: range check and cell address
   assign s4_hit_in = !s3_row_ff[R_BITS-1] && (s3_row_ff < $signed(R_BITS'(RHO_ROWS)))
                      && (s3_col_ff < ANGLE_BITS'(ANGLE_STEPS));

   always_comb begin
      dropped_in = dropped_ff;
      if (accept) begin
         dropped_in = '0;
      end else if (s3_valid_ff && s3_kind_ff == OP_VOTE && !s4_hit_in) begin
         dropped_in = dropped_ff + 1'b1;
      end
   end

   // stage 5: modify and write back; addresses within one sweep are distinct
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = s5_addr_ff;
      mem_wdata = '0;
      if (state_ff == ST_CLEAR) begin
         mem_we    = 1'b1;
         mem_waddr = clr_addr_ff;
      end else if (s5_valid_ff && s5_hit_ff) begin
         if (s5_kind_ff == OP_VOTE) begin
            mem_we    = 1'b1;
            mem_wdata = (mem_rdata_ff == COUNT_MAX) ? mem_rdata_ff : mem_rdata_ff + 1'b1;
         end else if (s5_kind_ff == OP_READ_CLEAR) begin
            mem_we = 1'b1;
         end
      end
   end

   always_comb begin
      count_in = count_ff;
      if (accept) begin
         count_in = '0;
      end else if (s5_valid_ff && s5_kind_ff != OP_VOTE) begin
         count_in = s5_hit_ff ? mem_rdata_ff : '0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         offset_ff    <= OFFSET_RESET;
         angle_ff     <= '0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         s5_valid_ff  <= 1'b0;
         dropped_ff   <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         offset_ff    <= offset_in;
         angle_ff     <= angle_in;
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s3_valid_in;
         s4_valid_ff  <= s3_valid_ff;
         s5_valid_ff  <= s4_valid_ff;
         dropped_ff   <= dropped_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         x_ff <= req_pixel_x;
         y_ff <= req_pixel_y;
      end
      s1_angle_ff <= angle_ff;
      s1_cos_ff   <= cos_val;
      s1_sin_ff   <= sin_val;
      s2_angle_ff <= s1_angle_ff;
      s2_px_ff    <= PROD_BITS'($signed({1'b0, x_ff}) * s1_cos_ff);
      s2_py_ff    <= PROD_BITS'($signed({1'b0, y_ff}) * s1_sin_ff);
      s3_kind_ff  <= s3_kind_in;
      s3_row_ff   <= s3_row_in;
      s3_col_ff   <= s3_col_in;
      s4_kind_ff  <= s3_kind_ff;
      s4_hit_ff   <= s4_hit_in;
      s4_addr_ff  <= ADDR_BITS'(s3_row_ff[ROW_BITS-1:0]) * ADDR_BITS'(ANGLE_STEPS)
                     + ADDR_BITS'(s3_col_ff);
      s5_kind_ff  <= s4_kind_ff;
      s5_hit_ff   <= s4_hit_ff;
      s5_addr_ff  <= s4_addr_ff;
      if (rsp_load) begin
         rsp_count_ff   <= count_ff;
         rsp_dropped_ff <= dropped_ff;
      end
   end

   // accumulator memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         vote_mem[mem_waddr] <= mem_wdata;
      end
      mem_rdata_ff <= vote_mem[s4_addr_ff];
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_cell_count    = rsp_count_ff;
   assign rsp_dropped_votes = rsp_dropped_ff;

endmodule

### test/hough_vote_checker.sv
// ----------------------------------------------------------------------------
// hough_vote_checker
// Watches the request, response and csr channels of the Hough line
// accumulator. It keeps its own vote tally and rho offset, works out the cell
// count and dropped-vote count of every request transfer, and compares each
// response transfer with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module hough_vote_checker
   import hla_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,

   input  logic                   req_valid,
   input  logic                   req_ready,
   input  logic [OP_BITS-1:0]     req_operation,
   input  logic [COORD_BITS_DEF-1:0] req_pixel_x,
   input  logic [COORD_BITS_DEF-1:0] req_pixel_y,
   input  logic                   req_pixel_is_edge,
   input  logic [ROW_IN_BITS-1:0] req_rho_row,
   input  logic [ANGLE_BITS-1:0]  req_angle_deg,

   input  logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  logic [COUNT_BITS-1:0]  rsp_cell_count,
   input  logic [DROP_BITS-1:0]   rsp_dropped_votes,

   input  logic                   csr_valid,
   input  logic                   csr_ready,
   input  logic [OFFSET_BITS-1:0] csr_rho_offset,

   output int                     fail_count,
   output int                     pending
);

   localparam int ANGLES = ANGLE_STEPS_DEF;
   localparam int ROWS   = RHO_ROWS_DEF;

   typedef struct packed {
      logic [COUNT_BITS-1:0] count;
      logic [DROP_BITS-1:0]  dropped;
   } cell_result_type;

   // sparse tally: absent key means a zero cell
   logic [COUNT_BITS-1:0] vote_tally [int];
   logic [OFFSET_BITS-1:0] offset_now;
   cell_result_type        cell_results_q [$];
   int                     quarter_q14 [0:90];

   initial begin
      fail_count = 0;
      pending = 0;
      offset_now = OFFSET_RESET;
      // nearest Q2.14 value of the exact sine
      for (int k = 0; k <= 90; k++) begin
         quarter_q14[k] = $rtoi(16384.0 * $sin(k * 3.14159265358979 / 180.0) + 0.5);
      end
   end

   function automatic int sin_q14(input int deg);
      int d;
      d = deg % 360;
      if (d <= 90) return quarter_q14[d];
      if (d <= 180) return quarter_q14[180 - d];
      if (d <= 270) return -quarter_q14[d - 180];
      return -quarter_q14[360 - d];
   endfunction

   function automatic cell_result_type tally_item(
      input logic [OP_BITS-1:0]        op,
      input logic [COORD_BITS_DEF-1:0] px,
      input logic [COORD_BITS_DEF-1:0] py,
      input logic                      is_edge,
      input logic [ROW_IN_BITS-1:0]    row,
      input logic [ANGLE_BITS-1:0]     ang
   );
      cell_result_type res;
      int acc, rho, slot, key, drops, t;
      res = '0;
      drops = 0;
      case (op)
         OP_VOTE: begin
            if (is_edge) begin
               for (t = 0; t < ANGLES; t++) begin
                  acc = int'(px) * sin_q14(t + 90) + int'(py) * sin_q14(t);
                  // truncate toward zero
                  rho = (acc >= 0) ? (acc >>> Q_SHIFT) : -((-acc) >>> Q_SHIFT);
                  slot = rho + int'(offset_now);
                  if (slot < 0 || slot >= ROWS) begin
                     drops++;
                  end else begin
                     key = slot * ANGLES + t;
                     if (!vote_tally.exists(key)) vote_tally[key] = 1;
                     else if (vote_tally[key] != COUNT_MAX) vote_tally[key]++;
                  end
               end
            end
         end
         OP_READ, OP_READ_CLEAR: begin
            if (int'(row) < ROWS && int'(ang) < ANGLES) begin
               key = int'(row) * ANGLES + int'(ang);
               if (vote_tally.exists(key)) begin
                  res.count = vote_tally[key];
                  if (op == OP_READ_CLEAR) vote_tally.delete(key);
               end
            end
         end
         default: ;
      endcase
      res.dropped = DROP_BITS'(drops);
      return res;
   endfunction

   always @(posedge clock) begin : watch
      cell_result_type want;
      if (reset) begin
         vote_tally.delete();
         cell_results_q.delete();
         offset_now = OFFSET_RESET;
         pending <= 0;
      end else begin
         if (csr_valid && csr_ready) offset_now = csr_rho_offset;
         // pop before push: a response never belongs to a same-edge request
         if (rsp_valid && rsp_ready) begin
            if (cell_results_q.size() == 0) begin
               $error("response transfer with no prediction outstanding");
               fail_count++;
            end else begin
               want = cell_results_q.pop_front();
               if (rsp_cell_count !== want.count) begin
                  $error("cell_count: expected %0d, actual %0d", want.count, rsp_cell_count);
                  fail_count++;
               end
               if (rsp_dropped_votes !== want.dropped) begin
                  $error("dropped_votes: expected %0d, actual %0d",
                         want.dropped, rsp_dropped_votes);
                  fail_count++;
               end
            end
         end
         if (req_valid && req_ready) begin
            cell_results_q.push_back(tally_item(req_operation, req_pixel_x, req_pixel_y,
                                                req_pixel_is_edge, req_rho_row,
                                                req_angle_deg));
         end
         pending <= cell_results_q.size();
      end
   end

endmodule

### test/hough_line_accumulator_core_tb.sv
// ----------------------------------------------------------------------------
// hough_line_accumulator_core_tb
// Drives the Hough line accumulator with a short directed set of votes, reads
// and read-clears, then random phases under several rho offsets, with bursty
// request traffic and response stalls. Checking is done by hough_vote_checker.
// ----------------------------------------------------------------------------
module hough_line_accumulator_core_tb
   import hla_pkg::*;
();

   localparam logic [OP_BITS-1:0] OP_UNUSED = 2'd3;
   localparam int ANGLES         = ANGLE_STEPS_DEF;
   localparam int HOT_PIXELS     = 8;
   localparam int PHASES         = 5;
   localparam int PHASE_ITEMS    = 300;
   localparam int CYCLE_LIMIT    = 5_000_000;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;

   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic [OP_BITS-1:0]        req_operation = OP_VOTE;
   logic [COORD_BITS_DEF-1:0] req_pixel_x = '0;
   logic [COORD_BITS_DEF-1:0] req_pixel_y = '0;
   logic                      req_pixel_is_edge = 1'b0;
   logic [ROW_IN_BITS-1:0]    req_rho_row = '0;
   logic [ANGLE_BITS-1:0]     req_angle_deg = '0;

   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic [COUNT_BITS-1:0]     rsp_cell_count;
   logic [DROP_BITS-1:0]      rsp_dropped_votes;

   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [OFFSET_BITS-1:0]    csr_rho_offset = OFFSET_RESET;

   int                        fail_count;
   int                        pending;
   int                        cycle_count = 0;
   int                        ready_run = 0;
   int                        burst_left = 0;
   logic                      quiet = 1'b0;
   logic [OFFSET_BITS-1:0]    cur_offset = OFFSET_RESET;
   logic [COORD_BITS_DEF-1:0] hot_x [HOT_PIXELS];
   logic [COORD_BITS_DEF-1:0] hot_y [HOT_PIXELS];

   always #6 clock = ~clock;

   hough_line_accumulator_core i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_operation     (req_operation),
      .req_pixel_x       (req_pixel_x),
      .req_pixel_y       (req_pixel_y),
      .req_pixel_is_edge (req_pixel_is_edge),
      .req_rho_row       (req_rho_row),
      .req_angle_deg     (req_angle_deg),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_cell_count    (rsp_cell_count),
      .rsp_dropped_votes (rsp_dropped_votes),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_rho_offset    (csr_rho_offset)
   );

   hough_vote_checker i_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_operation     (req_operation),
      .req_pixel_x       (req_pixel_x),
      .req_pixel_y       (req_pixel_y),
      .req_pixel_is_edge (req_pixel_is_edge),
      .req_rho_row       (req_rho_row),
      .req_angle_deg     (req_angle_deg),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_cell_count    (rsp_cell_count),
      .rsp_dropped_votes (rsp_dropped_votes),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_rho_offset    (csr_rho_offset),
      .fail_count        (fail_count),
      .pending           (pending)
   );

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // response stalls: short ready runs, short stalls, now and then a long open stretch
   always @(posedge clock) begin : rsp_stall
      int mode;
      if (ready_run > 0) begin
         ready_run <= ready_run - 1;
      end else begin
         mode = $urandom_range(0, 9);
         if (mode < 6) begin
            rsp_ready <= 1'b1;
            ready_run <= $urandom_range(1, 25);
         end else if (mode < 9) begin
            rsp_ready <= 1'b0;
            ready_run <= $urandom_range(1, 10);
         end else begin
            rsp_ready <= 1'b1;
            ready_run <= $urandom_range(100, 600);
         end
      end
   end

   // row hit by pixel (px, py) at angle ang, give or take one
   function automatic logic [ROW_IN_BITS-1:0] aim_row(input int px, input int py,
                                                      input int ang,
                                                      input logic [OFFSET_BITS-1:0] ofs);
      real rad;
      int rho;
      rad = ang * 3.14159265358979 / 180.0;
      rho = $rtoi(px * $cos(rad) + py * $sin(rad));
      return ROW_IN_BITS'(rho + int'(ofs) + int'($urandom_range(0, 2)) - 1);
   endfunction

   task automatic send(input logic [OP_BITS-1:0] op,
                       input logic [COORD_BITS_DEF-1:0] px,
                       input logic [COORD_BITS_DEF-1:0] py,
                       input logic is_edge,
                       input logic [ROW_IN_BITS-1:0] row,
                       input logic [ANGLE_BITS-1:0] ang);
      req_valid <= 1'b1;
      req_operation <= op;
      req_pixel_x <= px;
      req_pixel_y <= py;
      req_pixel_is_edge <= is_edge;
      req_rho_row <= row;
      req_angle_deg <= ang;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         burst_left = quiet ? 100000 : $urandom_range(0, 15);
      end
   endtask

   // hold off until every outstanding response has come back
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   task automatic write_offset(input logic [OFFSET_BITS-1:0] value);
      csr_valid <= 1'b1;
      csr_rho_offset <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      cur_offset = value;
   endtask

   task automatic refill_hot();
      for (int k = 0; k < HOT_PIXELS; k++) begin
         hot_x[k] = COORD_BITS_DEF'($urandom);
         hot_y[k] = COORD_BITS_DEF'($urandom);
      end
   endtask

   task automatic random_item();
      logic [OP_BITS-1:0]        op;
      logic [COORD_BITS_DEF-1:0] px, py;
      logic                      is_edge;
      logic [ROW_IN_BITS-1:0]    row;
      logic [ANGLE_BITS-1:0]     ang;
      int                        pick, h;
      px = COORD_BITS_DEF'($urandom);
      py = COORD_BITS_DEF'($urandom);
      is_edge = 1'($urandom);
      row = ROW_IN_BITS'($urandom);
      ang = ANGLE_BITS'($urandom);
      pick = $urandom_range(0, 99);
      h = $urandom_range(0, HOT_PIXELS - 1);
      if (pick < 45) begin
         op = OP_VOTE;
         is_edge = 1'b1;
         // repeat votes from a few pixels so their cells build up counts
         if ($urandom_range(0, 9) < 6) begin
            px = hot_x[h];
            py = hot_y[h];
         end
      end else if (pick < 53) begin
         op = OP_VOTE;
         is_edge = 1'b0;
      end else if (pick < 93) begin
         op = ($urandom_range(0, 4) == 0) ? OP_READ_CLEAR : OP_READ;
         if ($urandom_range(0, 3) != 0) begin
            ang = ANGLE_BITS'($urandom_range(0, ANGLES - 1));
            row = aim_row(hot_x[h], hot_y[h], ang, cur_offset);
         end
      end else begin
         op = OP_UNUSED;
      end
      send(op, px, py, is_edge, row, ang);
   endtask

   initial begin : stimulus
      logic [OFFSET_BITS-1:0] phase_offset;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      refill_hot();

      // directed, at the reset offset
      send(OP_VOTE, 8'd0, 8'd0, 1'b1, 10'd0, 9'd0);
      send(OP_READ, 8'd0, 8'd0, 1'b0, 10'(OFFSET_RESET), 9'd0);
      send(OP_READ, 8'd0, 8'd0, 1'b0, 10'(OFFSET_RESET), 9'd359);
      send(OP_VOTE, 8'd255, 8'd255, 1'b1, 10'd1023, 9'd511);
      send(OP_VOTE, 8'd255, 8'd255, 1'b0, 10'd0, 9'd0);
      send(OP_VOTE, 8'd255, 8'd0, 1'b1, 10'd0, 9'd0);
      send(OP_READ, 8'd0, 8'd0, 1'b0, 10'(OFFSET_RESET) + 10'd255, 9'd0);
      send(OP_READ_CLEAR, 8'd0, 8'd0, 1'b0, 10'(OFFSET_RESET) + 10'd255, 9'd0);
      send(OP_READ, 8'd0, 8'd0, 1'b0, 10'(OFFSET_RESET) + 10'd255, 9'd0);
      send(OP_VOTE, 8'd0, 8'd255, 1'b1, 10'd0, 9'd0);
      send(OP_READ, 8'd0, 8'd0, 1'b0, 10'(OFFSET_RESET) + 10'd255, 9'd90);
      send(OP_READ, 8'd0, 8'd0, 1'b0, 10'(OFFSET_RESET) - 10'd255, 9'd270);
      // reads past the last angle and at the last row
      send(OP_READ, 8'd255, 8'd255, 1'b1, 10'(OFFSET_RESET), 9'd360);
      send(OP_READ_CLEAR, 8'd0, 8'd0, 1'b0, 10'd1023, 9'd511);
      send(OP_READ, 8'd0, 8'd0, 1'b0, 10'd1023, 9'd359);
      send(OP_UNUSED, 8'd255, 8'd255, 1'b1, 10'd1023, 9'd511);
      send(OP_VOTE, 8'd128, 8'd77, 1'b1, 10'd0, 9'd0);
      send(OP_VOTE, 8'd128, 8'd77, 1'b1, 10'd0, 9'd0);
      send(OP_READ, 8'd0, 8'd0, 1'b0, aim_row(128, 77, 45, cur_offset), 9'd45);
      send(OP_READ_CLEAR, 8'd0, 8'd0, 1'b0, 10'd0, 9'd0);
      send(OP_READ, 8'd0, 8'd0, 1'b0, 10'(OFFSET_RESET), 9'd180);

      for (int phase = 0; phase < PHASES; phase++) begin
         settle();
         repeat (8) @(posedge clock);
         case (phase)
            0: phase_offset = '0;
            1: phase_offset = '1;
            default: phase_offset = OFFSET_BITS'($urandom);
         endcase
         write_offset(phase_offset);
         refill_hot();
         quiet = (phase == 2);
         burst_left = 0;
         repeat (PHASE_ITEMS) begin
            random_item();
            if ($urandom_range(0, 59) == 0) settle();
         end
      end

      settle();
      repeat (ANGLES + 16) @(posedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

### filelist.f
src/hla_pkg.sv
src/hough_line_accumulator_core.sv
test/hough_vote_checker.sv
test/hough_line_accumulator_core_tb.sv
